// ===== src/oahs_pkg.sv =====
// Shared types, codes and the control store for the hash set sequencer
package oahs_pkg;

	// Fixed field widths
	localparam int unsigned KEY_W = 31;
	localparam int unsigned CAP_W = 11;
	localparam int unsigned BIT_W = $clog2(KEY_W);

	// Action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// Request and response words
	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic       was_present;
		logic [1:0] status;
	} rsp_t;

	// Microcode address
	typedef logic [3:0] upc_t;

	localparam upc_t U_CLR   = 4'd0;
	localparam upc_t U_IDLE  = 4'd1;
	localparam upc_t U_ZCHK  = 4'd2;
	localparam upc_t U_DIV   = 4'd3;
	localparam upc_t U_READ  = 4'd4;
	localparam upc_t U_TEST  = 4'd5;
	localparam upc_t U_MTCH  = 4'd6;
	localparam upc_t U_ADV   = 4'd7;
	localparam upc_t U_FULL  = 4'd8;
	localparam upc_t U_STORE = 4'd9;
	localparam upc_t U_HIT   = 4'd10;
	localparam upc_t U_ZRES  = 4'd11;

	// Jump conditions
	typedef enum logic [3:0] {
		C_NONE,
		C_CLR_MORE,
		C_NO_REQ,
		C_KEY_ZERO,
		C_DIV_MORE,
		C_EMPTY,
		C_MATCH,
		C_EXHAUST,
		C_OUT_BUSY
	} cond_t;

	// Result to post
	typedef enum logic [2:0] {
		R_NONE,
		R_OK,
		R_HIT,
		R_FULL,
		R_ZERO
	} res_t;

	// One control word
	typedef struct packed {
		logic  clr_wr;
		logic  take;
		logic  div_step;
		logic  rd_en;
		logic  slot_adv;
		logic  wr_key;
		res_t  res;
		cond_t cond;
		upc_t  jmp;
		upc_t  nxt;
	} ucode_t;

	// Datapath flags seen by the sequencer
	typedef struct packed {
		logic clr_more;
		logic req_valid;
		logic key_zero;
		logic div_more;
		logic empty;
		logic match;
		logic exhaust;
		logic out_busy;
	} uflags_t;

	// Control store
	function automatic ucode_t ucode_rom(input upc_t pc);
		ucode_t w;
		w = '{clr_wr: 1'b0, take: 1'b0, div_step: 1'b0, rd_en: 1'b0, slot_adv: 1'b0,
			wr_key: 1'b0, res: R_NONE, cond: C_NONE, jmp: U_IDLE, nxt: U_IDLE};
		unique case (pc)
			U_CLR: begin
				w.clr_wr = 1'b1;
				w.cond   = C_CLR_MORE;
				w.jmp    = U_CLR;
				w.nxt    = U_IDLE;
			end
			U_IDLE: begin
				w.take = 1'b1;
				w.cond = C_NO_REQ;
				w.jmp  = U_IDLE;
				w.nxt  = U_ZCHK;
			end
			U_ZCHK: begin
				w.cond = C_KEY_ZERO;
				w.jmp  = U_ZRES;
				w.nxt  = U_DIV;
			end
			U_DIV: begin
				w.div_step = 1'b1;
				w.cond     = C_DIV_MORE;
				w.jmp      = U_DIV;
				w.nxt      = U_READ;
			end
			U_READ: begin
				w.rd_en = 1'b1;
				w.nxt   = U_TEST;
			end
			U_TEST: begin
				w.cond = C_EMPTY;
				w.jmp  = U_STORE;
				w.nxt  = U_MTCH;
			end
			U_MTCH: begin
				w.cond = C_MATCH;
				w.jmp  = U_HIT;
				w.nxt  = U_ADV;
			end
			U_ADV: begin
				w.slot_adv = 1'b1;
				w.cond     = C_EXHAUST;
				w.jmp      = U_FULL;
				w.nxt      = U_READ;
			end
			U_FULL: begin
				w.res  = R_FULL;
				w.cond = C_OUT_BUSY;
				w.jmp  = U_FULL;
				w.nxt  = U_IDLE;
			end
			U_STORE: begin
				w.wr_key = 1'b1;
				w.res    = R_OK;
				w.cond   = C_OUT_BUSY;
				w.jmp    = U_STORE;
				w.nxt    = U_IDLE;
			end
			U_HIT: begin
				w.res  = R_HIT;
				w.cond = C_OUT_BUSY;
				w.jmp  = U_HIT;
				w.nxt  = U_IDLE;
			end
			U_ZRES: begin
				w.res  = R_ZERO;
				w.cond = C_OUT_BUSY;
				w.jmp  = U_ZRES;
				w.nxt  = U_IDLE;
			end
			default: begin
				w.nxt = U_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== src/open_address_hash_set.sv =====
// A key of zero is answered with ST_ZERO and no probe. Else the home slot comes
// from a one bit per cycle modulo (31 steps); each probe reads a slot, where an
// empty one takes the key on insert or ends a lookup, a match is a hit, and else
// the probe advances. The next word is taken in U_IDLE after the response posts.
// Reset clears control at once, then zeroes all TABLE_DEPTH slots of the table
// while req_stall stays high; capacity writes are taken throughout.
module open_address_hash_set import oahs_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	localparam int unsigned AW      = $clog2(TABLE_DEPTH);
	localparam int unsigned CAP_MAX = (TABLE_DEPTH < ((1 << CAP_W) - 1)) ?
		TABLE_DEPTH : ((1 << CAP_W) - 1);
	localparam logic [CAP_W-1:0] CAP_LIM = CAP_W'(CAP_MAX);
	localparam logic [AW-1:0]    CLR_END = AW'(TABLE_DEPTH - 1);

	ucode_t  ctrl;
	uflags_t flags;

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] cap_eff;
	logic             action_q;
	logic [KEY_W-1:0] key_q;
	logic [BIT_W-1:0] bit_q;
	logic [CAP_W-1:0] slot_q;
	logic [CAP_W-1:0] step_q;
	logic [AW-1:0]    clr_q;
	logic [KEY_W-1:0] rd_data_q;
	logic [KEY_W-1:0] mem [TABLE_DEPTH];
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [CAP_W:0]   div_sum;
	logic [CAP_W:0]   div_nx;
	logic [CAP_W:0]   adv_sum;
	logic [CAP_W:0]   adv_nx;
	logic             accept;
	logic             out_busy;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [KEY_W-1:0] mem_wd;
	logic [AW-1:0]    slot_addr;

	oahs_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(1024);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Capacity in use: zero acts as one, clipped to the table depth
	assign cap_eff = (cap_q == '0) ? CAP_W'(1) : ((cap_q > CAP_LIM) ? CAP_LIM : cap_q);

	// Handshake
	assign req_stall = !ctrl.take;
	assign accept    = req_valid && ctrl.take;
	assign out_busy  = rsp_valid_q && rsp_stall;

	// Restoring modulo, one key bit per step
	assign div_sum = {slot_q, key_q[bit_q]};
	assign div_nx  = (div_sum >= {1'b0, cap_eff}) ? (div_sum - {1'b0, cap_eff}) : div_sum;

	// Triangular probe step, wrapped once
	assign adv_sum = {1'b0, slot_q} + {1'b0, step_q} + (CAP_W + 1)'(1);
	assign adv_nx  = (adv_sum >= {1'b0, cap_eff}) ? (adv_sum - {1'b0, cap_eff}) : adv_sum;

	// Flags for the sequencer
	assign flags.clr_more  = (clr_q != CLR_END);
	assign flags.req_valid = req_valid;
	assign flags.key_zero  = (key_q == '0);
	assign flags.div_more  = (bit_q != '0);
	assign flags.empty     = (rd_data_q == '0);
	assign flags.match     = (rd_data_q == key_q);
	assign flags.exhaust   = (({1'b0, step_q} + (CAP_W + 1)'(1)) == {1'b0, cap_eff});
	assign flags.out_busy  = out_busy;

	// Item registers; slot_q doubles as the modulo remainder
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= req.action;
			key_q    <= req.key;
			bit_q    <= BIT_W'(KEY_W - 1);
			slot_q   <= '0;
			step_q   <= '0;
		end else if (ctrl.div_step) begin
			slot_q <= div_nx[CAP_W-1:0];
			bit_q  <= bit_q - BIT_W'(1);
		end else if (ctrl.slot_adv) begin
			slot_q <= adv_nx[CAP_W-1:0];
			step_q <= step_q + CAP_W'(1);
		end
	end

	// Clearing sweep pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctrl.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Slot table, one write and one registered read port
	assign slot_addr = AW'(slot_q);
	assign mem_we    = ctrl.clr_wr || (ctrl.wr_key && (action_q == ACT_INSERT));
	assign mem_wa    = ctrl.clr_wr ? clr_q : slot_addr;
	assign mem_wd    = ctrl.clr_wr ? '0 : key_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem[slot_addr];
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((ctrl.res != R_NONE) && !out_busy) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.res != R_NONE) && !out_busy) begin
			case (ctrl.res)
				R_HIT:   rsp_q <= '{was_present: 1'b1, status: ST_OK};
				R_FULL:  rsp_q <= '{was_present: 1'b0, status: ST_FULL};
				R_ZERO:  rsp_q <= '{was_present: 1'b0, status: ST_ZERO};
				default: rsp_q <= '{was_present: 1'b0, status: ST_OK};
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== src/oahs_useq.sv =====
// Microcode sequencer: step counter, control store and jump logic
module oahs_useq import oahs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  uflags_t flags,
	output ucode_t  ctrl
);

	upc_t pc_q;
	logic take_jmp;

	assign ctrl = ucode_rom(pc_q);

	// Condition select
	always_comb begin
		unique case (ctrl.cond)
			C_NONE:     take_jmp = 1'b0;
			C_CLR_MORE: take_jmp = flags.clr_more;
			C_NO_REQ:   take_jmp = !flags.req_valid;
			C_KEY_ZERO: take_jmp = flags.key_zero;
			C_DIV_MORE: take_jmp = flags.div_more;
			C_EMPTY:    take_jmp = flags.empty;
			C_MATCH:    take_jmp = flags.match;
			C_EXHAUST:  take_jmp = flags.exhaust;
			C_OUT_BUSY: take_jmp = flags.out_busy;
			default:    take_jmp = 1'b0;
		endcase
	end

	// Step counter, starts with the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= U_CLR;
		end else begin
			pc_q <= take_jmp ? ctrl.jmp : ctrl.nxt;
		end
	end

endmodule
